@@ rtl/rse_pkg.sv @@
package rse_pkg;

	localparam int TAG_BITS    = 6;
	localparam int ROB_ENTRIES = 1 << TAG_BITS;
	localparam int VALUE_BITS  = 64;
	localparam int OP_BITS     = 6;
	localparam int OFFSET_BITS = 16;
	localparam int SRC_BITS    = TAG_BITS + 1;

	localparam logic [1:0] OPC_ISSUE     = 2'd0;
	localparam logic [1:0] OPC_BROADCAST = 2'd1;
	localparam logic [1:0] OPC_SQUASH    = 2'd2;
	localparam logic [1:0] OPC_RESERVED  = 2'd3;

	localparam logic KIND_DISPATCH  = 1'b0;
	localparam logic KIND_WRITEBACK = 1'b1;

	localparam logic [VALUE_BITS-1:0] SIGN_MASK = {1'b1, {(VALUE_BITS-1){1'b0}}};

	typedef struct packed {
		logic [1:0]                    opcode;
		logic [TAG_BITS-1:0]           rob_tag;
		logic signed [SRC_BITS-1:0]    tag_j;
		logic signed [SRC_BITS-1:0]    tag_k;
		logic [VALUE_BITS-1:0]         value_j;
		logic [VALUE_BITS-1:0]         value_k;
		logic [OP_BITS-1:0]            func_op;
		logic                          is_sub;
		logic signed [OFFSET_BITS-1:0] mem_offset;
		logic [TAG_BITS-1:0]           rob_front;
		logic [TAG_BITS-1:0]           rob_rear;
	} req_t;

	typedef struct packed {
		logic                          result_kind;
		logic [TAG_BITS-1:0]           out_tag;
		logic [OP_BITS-1:0]            out_op;
		logic [VALUE_BITS-1:0]         out_value_j;
		logic [VALUE_BITS-1:0]         out_value_k;
		logic signed [OFFSET_BITS-1:0] out_offset;
	} res_t;

endpackage

@@ rtl/rse_req_if.sv @@
interface rse_req_if
	import rse_pkg::*;
	;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    opcode;
	logic [TAG_BITS-1:0]           rob_tag;
	logic signed [SRC_BITS-1:0]    tag_j;
	logic signed [SRC_BITS-1:0]    tag_k;
	logic [VALUE_BITS-1:0]         value_j;
	logic [VALUE_BITS-1:0]         value_k;
	logic [OP_BITS-1:0]            func_op;
	logic                          is_sub;
	logic signed [OFFSET_BITS-1:0] mem_offset;
	logic [TAG_BITS-1:0]           rob_front;
	logic [TAG_BITS-1:0]           rob_rear;

	modport source (output valid, opcode, rob_tag, tag_j, tag_k, value_j, value_k,
		func_op, is_sub, mem_offset, rob_front, rob_rear, input ready);
	modport sink (input valid, opcode, rob_tag, tag_j, tag_k, value_j, value_k,
		func_op, is_sub, mem_offset, rob_front, rob_rear, output ready);
endinterface

@@ rtl/rse_res_if.sv @@
interface rse_res_if
	import rse_pkg::*;
	;
	logic                          valid;
	logic                          ready;
	logic                          result_kind;
	logic [TAG_BITS-1:0]           out_tag;
	logic [OP_BITS-1:0]            out_op;
	logic [VALUE_BITS-1:0]         out_value_j;
	logic [VALUE_BITS-1:0]         out_value_k;
	logic signed [OFFSET_BITS-1:0] out_offset;

	modport source (output valid, result_kind, out_tag, out_op, out_value_j,
		out_value_k, out_offset, input ready);
	modport sink (input valid, result_kind, out_tag, out_op, out_value_j,
		out_value_k, out_offset, output ready);
endinterface

@@ rtl/rse_cfg_if.sv @@
interface rse_cfg_if;
	logic valid;
	logic ready;
	logic is_float;

	modport source (output valid, is_float, input ready);
	modport sink (input valid, is_float, output ready);
endinterface

@@ rtl/reservation_station_entry_unit.sv @@
// Channel  Role    Handshake     Contents
// req      sink    valid/ready   issue, broadcast or squash request
// res      source  valid/ready   dispatch or write-back result
// cfg      sink    valid/ready   is_float register write
//
// A request is registered on entry and resolved against the entry state from that
// input register; its result is then registered in the output register and held
// there until it is taken.
// One request is accepted every cycle while the result register is free or drained.
// A stalled result holds the request stage, which then stops accepting.
// Reset frees the entry and clears is_float; configuration is always accepted.
module reservation_station_entry_unit
	import rse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	rse_req_if.sink   req,
	rse_res_if.source res,
	rse_cfg_if.sink   cfg
);

	logic valid_s1;
	req_t req_s1;
	logic advance;
	logic go;
	logic res_valid;
	res_t res_d;
	logic is_float_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_float_q <= 1'b0;
		end else if (cfg.valid) begin
			is_float_q <= cfg.is_float;
		end
	end

	assign go = valid_s1 && advance;

	rse_input_reg u_input (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1)
	);

	rse_entry_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.req_s1    (req_s1),
		.is_float  (is_float_q),
		.res_valid (res_valid),
		.res       (res_d)
	);

	rse_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.res_valid (res_valid),
		.res_d     (res_d),
		.advance   (advance),
		.res       (res)
	);

endmodule

@@ rtl/rse_input_reg.sv @@
module rse_input_reg
	import rse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	rse_req_if.sink   req,
	input  logic      advance,
	output logic      valid_s1,
	output req_t      req_s1
);

	logic load;

	// A request is taken whenever the stage is empty or moves on this cycle.
	assign req.ready = !valid_s1 || advance;
	assign load      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			req_s1.opcode     <= req.opcode;
			req_s1.rob_tag    <= req.rob_tag;
			req_s1.tag_j      <= req.tag_j;
			req_s1.tag_k      <= req.tag_k;
			req_s1.value_j    <= req.value_j;
			req_s1.value_k    <= req.value_k;
			req_s1.func_op    <= req.func_op;
			req_s1.is_sub     <= req.is_sub;
			req_s1.mem_offset <= req.mem_offset;
			req_s1.rob_front  <= req.rob_front;
			req_s1.rob_rear   <= req.rob_rear;
		end
	end

endmodule

@@ rtl/rse_entry_core.sv @@
module rse_entry_core
	import rse_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  go,
	input  req_t  req_s1,
	input  logic  is_float,
	output logic  res_valid,
	output res_t  res
);

	logic                          busy_q;
	logic                          ready_j_q;
	logic                          ready_k_q;
	logic                          sub_q;
	logic                          awaiting_q;
	logic [TAG_BITS-1:0]           dest_tag_q;
	logic [TAG_BITS-1:0]           src_j_q;
	logic [TAG_BITS-1:0]           src_k_q;
	logic [VALUE_BITS-1:0]         opnd_j_q;
	logic [VALUE_BITS-1:0]         opnd_k_q;
	logic [OP_BITS-1:0]            op_q;
	logic signed [OFFSET_BITS-1:0] offset_q;

	logic                          busy_d;
	logic                          ready_j_d;
	logic                          ready_k_d;
	logic                          sub_d;
	logic                          awaiting_d;
	logic [TAG_BITS-1:0]           dest_tag_d;
	logic [TAG_BITS-1:0]           src_j_d;
	logic [TAG_BITS-1:0]           src_k_d;
	logic [VALUE_BITS-1:0]         opnd_j_d;
	logic [VALUE_BITS-1:0]         opnd_k_d;
	logic [OP_BITS-1:0]            op_d;
	logic signed [OFFSET_BITS-1:0] offset_d;

	logic [TAG_BITS-1:0]   dist_b;
	logic [TAG_BITS-1:0]   dist_r;
	logic [TAG_BITS-1:0]   dist_dest;
	logic [TAG_BITS-1:0]   dist_j;
	logic [TAG_BITS-1:0]   dist_k;
	logic                  squash_hit;
	logic [VALUE_BITS-1:0] k_out;

	// Distances from the oldest reorder-buffer entry; the ring size equals 2**TAG_BITS.
	assign dist_b    = req_s1.rob_tag - req_s1.rob_front;
	assign dist_r    = req_s1.rob_rear - req_s1.rob_front;
	assign dist_dest = dest_tag_q - req_s1.rob_front;
	assign dist_j    = src_j_q - req_s1.rob_front;
	assign dist_k    = src_k_q - req_s1.rob_front;

	assign squash_hit = (dist_b < dist_dest && dist_dest <= dist_r)
		|| (!ready_j_q && dist_b < dist_j && dist_j <= dist_r)
		|| (!ready_k_q && dist_b < dist_k && dist_k <= dist_r);

	always_comb begin
		busy_d     = busy_q;
		ready_j_d  = ready_j_q;
		ready_k_d  = ready_k_q;
		sub_d      = sub_q;
		awaiting_d = awaiting_q;
		dest_tag_d = dest_tag_q;
		src_j_d    = src_j_q;
		src_k_d    = src_k_q;
		opnd_j_d   = opnd_j_q;
		opnd_k_d   = opnd_k_q;
		op_d       = op_q;
		offset_d   = offset_q;
		res_valid  = 1'b0;
		res        = '0;

		unique case (req_s1.opcode)
			OPC_ISSUE: begin
				busy_d     = 1'b1;
				dest_tag_d = req_s1.rob_tag;
				src_j_d    = req_s1.tag_j[TAG_BITS-1:0];
				src_k_d    = req_s1.tag_k[TAG_BITS-1:0];
				// A negative producer tag means the value came with the request.
				ready_j_d  = req_s1.tag_j[SRC_BITS-1];
				ready_k_d  = req_s1.tag_k[SRC_BITS-1];
				opnd_j_d   = req_s1.value_j;
				opnd_k_d   = req_s1.value_k;
				op_d       = req_s1.func_op;
				sub_d      = req_s1.is_sub;
				offset_d   = req_s1.mem_offset;
				awaiting_d = 1'b1;
			end
			OPC_BROADCAST: begin
				if (busy_q && req_s1.rob_tag == dest_tag_q) begin
					busy_d          = 1'b0;
					awaiting_d      = 1'b0;
					res_valid       = 1'b1;
					res.result_kind = KIND_WRITEBACK;
					res.out_tag     = dest_tag_q;
					res.out_value_j = req_s1.value_j;
				end else if (busy_q) begin
					if (!ready_j_q && req_s1.rob_tag == src_j_q) begin
						opnd_j_d  = req_s1.value_j;
						ready_j_d = 1'b1;
					end
					if (!ready_k_q && req_s1.rob_tag == src_k_q) begin
						opnd_k_d  = req_s1.value_j;
						ready_k_d = 1'b1;
					end
				end
			end
			OPC_SQUASH: begin
				if (busy_q && squash_hit) begin
					busy_d     = 1'b0;
					awaiting_d = 1'b0;
				end
			end
			default: begin
			end
		endcase

		// Dispatch as soon as both operands are in, whether at issue or after a capture.
		if ((req_s1.opcode == OPC_ISSUE || req_s1.opcode == OPC_BROADCAST)
			&& !res_valid && awaiting_d && ready_j_d && ready_k_d) begin
			awaiting_d      = 1'b0;
			res_valid       = 1'b1;
			res.result_kind = KIND_DISPATCH;
			res.out_tag     = dest_tag_d;
			res.out_op      = op_d;
			res.out_value_j = opnd_j_d;
			res.out_value_k = k_out;
			res.out_offset  = offset_d;
		end
	end

	always_comb begin
		if (!sub_d) begin
			k_out = opnd_k_d;
		end else if (is_float) begin
			k_out = opnd_k_d ^ SIGN_MASK;
		end else begin
			k_out = ~opnd_k_d + VALUE_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			ready_j_q  <= 1'b1;
			ready_k_q  <= 1'b1;
			sub_q      <= 1'b0;
			awaiting_q <= 1'b0;
		end else if (go) begin
			busy_q     <= busy_d;
			ready_j_q  <= ready_j_d;
			ready_k_q  <= ready_k_d;
			sub_q      <= sub_d;
			awaiting_q <= awaiting_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dest_tag_q <= dest_tag_d;
			src_j_q    <= src_j_d;
			src_k_q    <= src_k_d;
			opnd_j_q   <= opnd_j_d;
			opnd_k_q   <= opnd_k_d;
			op_q       <= op_d;
			offset_q   <= offset_d;
		end
	end

	a_wait_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		awaiting_q |-> busy_q)
		else $error("entry waits for dispatch while free");

	a_writeback_frees: assert property (@(posedge clk) disable iff (!arst_n)
		go && res_valid && res.result_kind == KIND_WRITEBACK |=> !busy_q)
		else $error("entry still busy after write-back");

	a_dispatch_once: assert property (@(posedge clk) disable iff (!arst_n)
		go && res_valid && res.result_kind == KIND_DISPATCH |=> !awaiting_q)
		else $error("entry still waiting after dispatch");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!go |=> $stable(busy_q) && $stable(awaiting_q))
		else $error("entry state changed without a request");

endmodule

@@ rtl/rse_result_reg.sv @@
module rse_result_reg
	import rse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      go,
	input  logic      res_valid,
	input  res_t      res_d,
	output logic      advance,
	rse_res_if.source res
);

	logic valid_q;
	res_t res_q;

	// The register may be refilled in the cycle its contents are taken.
	assign advance = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= go && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res_valid) begin
			res_q <= res_d;
		end
	end

	assign res.valid       = valid_q;
	assign res.result_kind = res_q.result_kind;
	assign res.out_tag     = res_q.out_tag;
	assign res.out_op      = res_q.out_op;
	assign res.out_value_j = res_q.out_value_j;
	assign res.out_value_k = res_q.out_value_k;
	assign res.out_offset  = res_q.out_offset;

endmodule
